// File: rtl/c3dc_pkg.sv
// ----------------------------------------------------------------------------
// c3dc_pkg
// Shared types and constants of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3dc_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIX_W         = 8;
    localparam int COEF_W        = 16;
    localparam int ROW_W         = 3 * COEF_W;
    localparam int DIM_W         = 13;            // holds any row length or height
    localparam int PROD_W        = PIX_W + COEF_W + 1;
    localparam int COL_W         = PROD_W + 2;    // three products
    localparam int SUM_W         = COL_W + 1;     // three columns, signed
    localparam int CFG_ADDR_W    = 3;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEFF_TOP = 3'd0,
        REG_COEFF_MID = 3'd1,
        REG_COEFF_BOT = 3'd2,
        REG_DIVISOR   = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_HEIGHT    = 3'd5
    } t_reg_idx;

    // control from the sequencer to the cell chain
    typedef struct packed {
        logic shift;
        logic mul;
        logic colsum;
    } t_cell_ctrl;

    // divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] q;
    } t_div_res;

endpackage

// File: rtl/c3dc_cell.sv
// ----------------------------------------------------------------------------
// c3dc_cell
// One window column: three pixels, their products with one kernel column,
// and the column sum. Pixels move on to the left neighbor on each shift.
// ----------------------------------------------------------------------------
module c3dc_cell
    import c3dc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_ctrl                   i_ctrl,
    input  logic [2:0][PIX_W-1:0]        i_col,     // top, mid, bottom
    input  logic signed [2:0][COEF_W-1:0] i_coef,   // top, mid, bottom
    output logic [2:0][PIX_W-1:0]        o_col,
    output logic signed [COL_W-1:0]      o_sum
);

    logic [2:0][PIX_W-1:0]         r_px;
    logic signed [PROD_W-1:0]      r_prod [3];
    logic signed [COL_W-1:0]       r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
        end else if (i_ctrl.shift) begin
            r_px <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PROD_W'($signed({1'b0, r_px[k]}) * $signed(i_coef[k]));
            end
        end
        if (i_ctrl.colsum) begin
            r_sum <= COL_W'(r_prod[0]) + COL_W'(r_prod[1]) + COL_W'(r_prod[2]);
        end
    end

    assign o_col = r_px;
    assign o_sum = r_sum;

endmodule

// File: rtl/c3dc_div.sv
// ----------------------------------------------------------------------------
// c3dc_div
// Divide and clamp to 0..255. Negative sums clamp to zero; a divisor of one or less passes the sum through, clamped;
// otherwise an 8-step restoring division, since any quotient of 256 or more saturates.
// ----------------------------------------------------------------------------
module c3dc_div
    import c3dc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_sum,
    input  logic signed [COEF_W-1:0] i_div,
    output t_div_res                 o_res
);

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN} t_dstate;

    t_dstate                  r_state;
    logic signed [SUM_W-1:0]  r_rem;
    logic signed [COEF_W-1:0] r_div;
    logic [SUM_W-1:0]         r_dsh;
    logic [PIX_W-1:0]         r_q;
    logic [2:0]               r_step;
    logic                     r_done;

    logic [SUM_W-1:0] w_lim;
    logic [SUM_W-1:0] w_rem_u;
    assign w_lim   = SUM_W'({r_div[COEF_W-2:0], 8'd0});
    assign w_rem_u = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_rem   <= i_sum;
                        r_div   <= i_div;
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    r_dsh  <= SUM_W'({r_div[COEF_W-2:0], 7'd0});
                    r_step <= 3'd7;
                    if (r_rem <= 0) begin
                        r_q     <= '0;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else if (r_div <= 1) begin
                        r_q     <= (w_rem_u > SUM_W'(PIX_MAX)) ? PIX_MAX : r_rem[PIX_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else if (w_rem_u >= w_lim) begin
                        r_q     <= PIX_MAX;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_q     <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (w_rem_u >= r_dsh) begin
                        r_rem         <= $signed(w_rem_u - r_dsh);
                        r_q[r_step]   <= 1'b1;
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.q    = r_q;

endmodule

// File: rtl/conv3x3_divide_clamp_top.sv
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_top
// 3x3 convolution over a raster pixel stream with divide and clamp.
// ----------------------------------------------------------------------------
// One pixel is taken per transaction and processed alone: an interior pixel
// passes through line buffer read, window shift, product, column sum, total,
// then up to 8 steps of the shared divider plus its checks; a border pixel
// stops after the total. The divider's one-bit-per-cycle loop is the longest
// part of an interior pixel's work. The result register lets the next pixel
// enter while a result waits. Border pixels give no output; tlast marks the
// last interior pixel of a frame. Configuration writes are accepted every cycle and act at once.
module conv3x3_divide_clamp_top
    import c3dc_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_in
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic                   m_axis_tlast,   // frame_last
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ROW_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_COL, S_SUM, S_DIV, S_OUT
    } t_state;

    // configuration
    logic [ROW_W-1:0]         r_coef [3];
    logic signed [COEF_W-1:0] r_div;
    logic [10:0]              r_width;
    logic [10:0]              r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= '0;
            r_coef[1] <= ROW_W'(65536);
            r_coef[2] <= '0;
            r_div     <= 16'sd1;
            r_width   <= 11'd1024;
            r_height  <= 11'd768;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_COEFF_TOP: r_coef[0] <= i_cfg_data;
                REG_COEFF_MID: r_coef[1] <= i_cfg_data;
                REG_COEFF_BOT: r_coef[2] <= i_cfg_data;
                REG_DIVISOR:   r_div     <= i_cfg_data[COEF_W-1:0];
                REG_WIDTH:     r_width   <= i_cfg_data[10:0];
                REG_HEIGHT:    r_height  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    logic [DIM_W-1:0] w_w;
    logic [DIM_W-1:0] w_h;
    always_comb begin
        if (r_width < 11'd3)                       w_w = DIM_W'(3);
        else if (DIM_W'(r_width) > DIM_W'(MAX_WIDTH)) w_w = DIM_W'(MAX_WIDTH);
        else                                       w_w = DIM_W'(r_width);
        if (r_height < 11'd3)                      w_h = DIM_W'(3);
        else if (DIM_W'(r_height) > DIM_W'(MAX_HEIGHT)) w_h = DIM_W'(MAX_HEIGHT);
        else                                       w_h = DIM_W'(r_height);
    end

    // sequencer
    t_state           r_state;
    logic [AW-1:0]    r_col;
    logic [9:0]       r_row;
    logic [AW-1:0]    r_addr;
    logic [PIX_W-1:0] r_pix;
    logic             r_inner;
    logic             r_last;
    logic [PIX_W-1:0] r_q;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;

    logic             w_acc;
    logic             w_col_end;
    logic             w_row_end;
    t_div_res         w_div;
    logic             w_out_free;

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_col_end  = (DIM_W'(r_col) + DIM_W'(1)) >= w_w;
    assign w_row_end  = (DIM_W'(r_row) + DIM_W'(1)) >= w_h;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // line buffers: low byte two rows up, high byte one row up
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= r_mem[r_col];
        end
        if (r_state == S_LOAD) begin
            r_mem[r_addr] <= {r_pix, r_rd[2*PIX_W-1:PIX_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_addr  <= r_col;
                        r_pix   <= s_axis_tdata;
                        r_inner <= (r_row >= 10'd2) && (r_col >= AW'(2));
                        r_last  <= w_row_end && w_col_end;
                        if (w_col_end) begin
                            r_col <= '0;
                            r_row <= w_row_end ? 10'd0 : r_row + 10'd1;
                        end else begin
                            r_col <= r_col + AW'(1);
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= S_MUL;
                S_MUL:  r_state <= S_COL;
                S_COL:  r_state <= S_SUM;
                S_SUM:  r_state <= r_inner ? S_DIV : S_IDLE;
                S_DIV: begin
                    if (w_div.done) begin
                        r_q     <= w_div.q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_q;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    // cell chain: cell 2 takes the new column, cell 0 is the left column
    t_cell_ctrl                 w_ctrl;
    logic [2:0][PIX_W-1:0]      w_col [4];
    logic signed [COL_W-1:0]    w_csum [3];

    assign w_ctrl.shift  = (r_state == S_LOAD);
    assign w_ctrl.mul    = (r_state == S_MUL);
    assign w_ctrl.colsum = (r_state == S_COL);
    assign w_col[3]      = {r_pix, r_rd[2*PIX_W-1:PIX_W], r_rd[PIX_W-1:0]};

    for (genvar k = 0; k < 3; k++) begin : g_cell
        logic signed [2:0][COEF_W-1:0] w_coef;
        for (genvar r = 0; r < 3; r++) begin : g_coef
            assign w_coef[r] = r_coef[r][COEF_W*k +: COEF_W];
        end
        c3dc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_col   (w_col[k+1]),
            .i_coef  (w_coef),
            .o_col   (w_col[k]),
            .o_sum   (w_csum[k])
        );
    end

    logic signed [SUM_W-1:0] w_sum;
    assign w_sum = SUM_W'(w_csum[0]) + SUM_W'(w_csum[1]) + SUM_W'(w_csum[2]);

    c3dc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_SUM) && r_inner),
        .i_sum   (w_sum),
        .i_div   (r_div),
        .o_res   (w_div)
    );

endmodule

// File: sim/tb_conv3x3_divide_clamp_top.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_divide_clamp_top
// Self-checking bench for the 3x3 convolution filter with divide and clamp.
// Raster pixels go in on the slave stream; a line-buffer/window predictor
// computes every interior result, and each output transaction is checked in
// order. Directed frames first, then random frames of random kernels, divisors
// and sizes, with random stalls on both streams, then frames at size extremes.
// ----------------------------------------------------------------------------
module tb_conv3x3_divide_clamp_top;
    import c3dc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [PIX_W-1:0] pix;
        bit               last;
    } t_filt_res;

    typedef struct {
        logic [PIX_W-1:0] pix;     // pixel sent
        bit               typed;   // result given below instead of predicted
        logic [PIX_W-1:0] res;
        bit               last;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [ROW_W-1:0]      i_cfg_data;

    conv3x3_divide_clamp_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor state
    logic [PIX_W-1:0]        lbuf [2][DEF_MAX_WIDTH];
    logic [PIX_W-1:0]        win  [3][2];
    int unsigned             col_pos, row_pos;
    logic [ROW_W-1:0]        kern [3];
    logic signed [COEF_W-1:0] div_reg;
    logic [10:0]             width_reg, height_reg;

    t_filt_res  pending_q [$];
    int         mismatches;
    bit         calm;          // no idling on either side
    int         hold_req;      // bumped to ask the receiver for a long hold-off

    task automatic filt_reset();
        foreach (lbuf[i, j]) lbuf[i][j] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
        kern[0] = '0;
        kern[1] = 48'h0000_0001_0000;
        kern[2] = '0;
        div_reg = 16'sd1;
        width_reg = 11'd1024;
        height_reg = 11'd768;
    endtask

    task automatic filt_pixel(input logic [PIX_W-1:0] p, output bit got,
                              output t_filt_res r);
        int unsigned w, h, ci;
        logic [PIX_W-1:0] px [3][3];
        longint acc;
        logic signed [COEF_W-1:0] c;
        w = width_reg < 3 ? 3 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
        h = height_reg < 3 ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        ci = col_pos < DEF_MAX_WIDTH ? col_pos : DEF_MAX_WIDTH - 1;
        px[0][2] = lbuf[0][ci];
        px[1][2] = lbuf[1][ci];
        px[2][2] = p;
        for (int i = 0; i < 3; i++) begin
            px[i][0] = win[i][0];
            px[i][1] = win[i][1];
            win[i][0] = px[i][1];
            win[i][1] = px[i][2];
        end
        lbuf[0][ci] = px[1][2];
        lbuf[1][ci] = px[2][2];
        got = 0;
        r.pix = '0;
        r.last = 0;
        if (row_pos >= 2 && col_pos >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) begin
                    c = kern[i][16*k +: 16];
                    acc += longint'(px[i][k]) * longint'(c);
                end
            if (div_reg > 1) acc = acc / longint'(div_reg);
            if (acc < 0) acc = 0;
            if (acc > PIX_MAX) acc = PIX_MAX;
            r.pix = acc[PIX_W-1:0];
            r.last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
            got = 1;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver ready: random gaps plus requested long hold-offs
    initial begin
        int gap_left, hold_left, hold_seen;
        gap_left = 0;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_filt_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pix=%0d last=%0b", m_axis_tdata, m_axis_tlast);
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tdata !== e.pix || m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pix=%0d last=%0b, got pix=%0d last=%0b",
                                 e.pix, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed = 0,
                              input t_filt_res typed_res = '{default: 0});
        int n;
        bit got;
        t_filt_res r;
        n = pick_gap();
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        filt_pixel(p, got, r);
        if (got) pending_q.push_back(typed ? typed_res : r);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender pauses until every result is back and the block has drained
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [ROW_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COEFF_TOP: kern[0] = val;
            REG_COEFF_MID: kern[1] = val;
            REG_COEFF_BOT: kern[2] = val;
            REG_DIVISOR:   div_reg = val[15:0];
            REG_WIDTH:     width_reg = val[10:0];
            REG_HEIGHT:    height_reg = val[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        if ($urandom_range(0, 9) == 0)
            return 48'({$urandom(), $urandom()});
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic logic [ROW_W-1:0] rand_divisor();
        case ($urandom_range(0, 7))
            0: return 48'd1;
            1: return 48'd0;
            2: return 48'(16'($urandom_range(32768, 65535)));
            3: return 48'd32767;
            4: return 48'h8000;
            5: return 48'(16'($urandom()));
            default: return 48'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_dim();
        if ($urandom_range(0, 9) == 0) return 48'($urandom_range(0, 2));
        return 48'($urandom_range(3, 10));
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 15))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic set_size(input logic [ROW_W-1:0] w, input logic [ROW_W-1:0] h);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
    endtask

    task automatic run_frame(input bit mid_change);
        int unsigned w, h;
        w = width_reg < 3 ? 3 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
        h = height_reg < 3 ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        for (int i = 0; i < w * h; i++) begin
            if (mid_change && i == (w * h) / 2) begin
                drain();
                cfg_write(REG_COEFF_MID, rand_row());
                cfg_write(REG_DIVISOR, rand_divisor());
            end
            send_pixel(rand_pixel());
        end
    endtask

    t_dir_row dir_tab [27] = '{
        // identity kernel, 3x3: result is the centre pixel
        '{8'd0,   0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd0,   0, 8'd0,   0},
        '{8'd255, 0, 8'd0,   0}, '{8'd128, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0},
        '{8'd0,   0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd0,   1, 8'd128, 1},
        // all full scale through identity
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0},
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0},
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 1, 8'd255, 1},
        // negative middle row: clamps to zero
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0},
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0},
        '{8'd255, 0, 8'd0,   0}, '{8'd255, 0, 8'd0,   0}, '{8'd255, 1, 8'd0,   1}
    };

    initial begin
        int items;
        int phase;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_addr <= REG_COEFF_TOP;
        i_cfg_data <= '0;
        mismatches = 0;
        calm = 0;
        hold_req = 0;
        filt_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_size(48'd3, 48'd3);
        foreach (dir_tab[i]) begin
            if (i == 18) begin
                drain();
                cfg_write(REG_COEFF_MID, 48'hFFFF_FFFF_FFFF);
            end
            send_pixel(dir_tab[i].pix, dir_tab[i].typed,
                       '{pix: dir_tab[i].res, last: dir_tab[i].last});
        end
        drain();

        items = 0;
        phase = 0;
        while (items < 1300) begin
            calm = (phase % 5 == 4);
            cfg_write(REG_COEFF_TOP, rand_row());
            cfg_write(REG_COEFF_MID, rand_row());
            cfg_write(REG_COEFF_BOT, rand_row());
            cfg_write(REG_DIVISOR, rand_divisor());
            set_size(rand_dim(), rand_dim());
            if (phase == 3) hold_req++;   // receiver holds off while input backs up
            repeat ($urandom_range(1, 2)) begin
                run_frame($urandom_range(0, 3) == 0);
                items += (width_reg < 3 ? 3 : width_reg) * (height_reg < 3 ? 3 : height_reg);
            end
            drain();
            phase++;
        end

        // size extremes: both above range, then shrinking past the counters
        calm = 0;
        cfg_write(REG_DIVISOR, 48'd9);
        cfg_write(REG_COEFF_TOP, {16'd1, 16'd1, 16'd1});
        cfg_write(REG_COEFF_MID, {16'd1, 16'd1, 16'd1});
        cfg_write(REG_COEFF_BOT, {16'd1, 16'd1, 16'd1});
        set_size(48'd2047, 48'd2047);
        for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
        drain();
        // column already past the new width: row wraps on the next pixel
        set_size(48'd3, 48'd2047);
        for (int i = 0; i < 30; i++) send_pixel(rand_pixel());
        drain();
        // row already past the new height: frame ends at the end of this row
        set_size(48'd3, 48'd3);
        for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
        drain();

        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
